// ----- design/vns_pkg.sv -----
package vns_pkg;

   localparam int CoordBits = 32;
   localparam int FracBits  = 16;
   localparam int ValueBits = 24;
   localparam int IdxBits   = CoordBits - FracBits;

   localparam logic [31:0] MulX = 32'h27D4EB2D;
   localparam logic [31:0] MulY = 32'h9E3779B9;
   localparam logic [31:0] MulZ = 32'h165667B1;
   localparam logic [31:0] FinA = 32'h85EBCA6B;
   localparam logic [31:0] FinB = 32'hC2B2AE35;

   typedef logic [FracBits-1:0]  frac_type;
   typedef logic [ValueBits-1:0] value_type;

   typedef struct packed {
      logic [31:0] hx0;
      logic [31:0] hx1;
      logic [31:0] hy0;
      logic [31:0] hy1;
      logic [31:0] hz0;
      logic [31:0] hz1;
   } axis_hash_type;

   typedef struct packed {
      frac_type fx;
      frac_type fy;
      frac_type fz;
   } frac3_type;

   // blend of two values, weight in q0.f
   function automatic value_type blend(input value_type a, input value_type b,
                                       input frac_type w);
      logic [ValueBits+FracBits:0] s;
      s = {1'b0, a} * ({1'b1, {FracBits{1'b0}}} - {1'b0, w}) + {1'b0, b} * {1'b0, w};
      return s[ValueBits+FracBits-1:FracBits];
   endfunction

endpackage

// ----- design/vns_fade.sv -----
module vns_fade (
   input  logic              clock,
   input  logic              en,
   input  vns_pkg::frac_type t,
   output vns_pkg::frac_type fade
);
   import vns_pkg::*;

   localparam int OneVal = 1 << FracBits;

   logic [FracBits-1:0]   t_ff,  t2_ff, t3_ff;
   logic [FracBits+3:0]   p_ff;
   logic [FracBits+3:0]   p_in;
   logic [2*FracBits-1:0] sq_in, cu_in;
   logic [2*FracBits+3:0] f_in;
   logic [FracBits-1:0]   fade_ff;

   assign sq_in = t * t;
   assign cu_in = t2_ff * t_ff;
   assign p_in  = (FracBits+4)'(6 * int'(t2_ff) + 10 * OneVal - 15 * int'(t_ff));
   assign f_in  = t3_ff * p_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff    <= t;
         t2_ff   <= sq_in[2*FracBits-1:FracBits];
         t3_ff   <= cu_in[2*FracBits-1:FracBits];
         p_ff    <= p_in;
         fade_ff <= f_in[2*FracBits-1:FracBits];
      end
   end

   assign fade = fade_ff;

endmodule

// ----- design/vns_corner.sv -----
module vns_corner (
   input  logic               clock,
   input  logic               en,
   input  logic [31:0]        seed,
   input  logic [31:0]        hx,
   input  logic [31:0]        hy,
   input  logic [31:0]        hz,
   output vns_pkg::value_type value
);
   import vns_pkg::*;

   logic [31:0] h0_ff, h1_ff, h2_ff;
   logic [31:0] h0_in, h1_in, h2_in;

   assign h0_in = (seed ^ hx ^ hy ^ hz);
   assign h1_in = (h0_ff ^ (h0_ff >> 15)) * FinA;
   assign h2_in = (h1_ff ^ (h1_ff >> 13)) * FinB;

   always_ff @(posedge clock) begin
      if (en) begin
         h0_ff <= h0_in;
         h1_ff <= h1_in;
         h2_ff <= h2_in;
      end
   end

   logic [31:0] hf;
   assign hf    = h2_ff ^ (h2_ff >> 16);
   assign value = hf[31 -: ValueBits];

endmodule

// ----- design/value_noise_3d_sampler.sv -----
// 3d value noise sampler: one q16.16 point per transaction, one 24-bit
// noise value back. fully pipelined, accepts a point every cycle while
// the output stage is not stalled, through seven register stages; the
// corner hash path (coordinate products, then the
// two 32-bit multiplies of the finalizer) and the three blend levels set
// the depth. req_tready drops only while the output stage holds an
// untaken result.
module value_noise_3d_sampler (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,    // seed
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,    // coord_x, coord_y, coord_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata     // noise_value
);
   import vns_pkg::*;

   localparam int Depth = 7;

   logic [31:0] seed_ff;
   logic [Depth-1:0] vld_ff;
   logic en;

   always_ff @(posedge clock) begin
      if (reset) seed_ff <= '0;
      else if (csr_we) seed_ff <= csr_wdata;
   end

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[Depth-1];

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[Depth-2:0], req_tvalid};
   end

   // stage 1: split and axis products
   logic [IdxBits-1:0] ix, iy, iz;
   logic [31:0] x0, y0, z0;
   axis_hash_type ah_ff, ah_in;
   frac3_type fr_in;
   assign ix = req_tdata[31:FracBits];
   assign iy = req_tdata[63:32+FracBits];
   assign iz = req_tdata[95:64+FracBits];
   assign x0 = {{FracBits{ix[IdxBits-1]}}, ix};
   assign y0 = {{FracBits{iy[IdxBits-1]}}, iy};
   assign z0 = {{FracBits{iz[IdxBits-1]}}, iz};
   assign fr_in.fx = req_tdata[FracBits-1:0];
   assign fr_in.fy = req_tdata[32+FracBits-1:32];
   assign fr_in.fz = req_tdata[64+FracBits-1:64];
   assign ah_in.hx0 = x0 * MulX;
   assign ah_in.hx1 = (x0 + 32'd1) * MulX;
   assign ah_in.hy0 = y0 * MulY;
   assign ah_in.hy1 = (y0 + 32'd1) * MulY;
   assign ah_in.hz0 = z0 * MulZ;
   assign ah_in.hz1 = (z0 + 32'd1) * MulZ;

   always_ff @(posedge clock) begin
      if (en) ah_ff <= ah_in;
   end

   // fades: registered in vns_fade, then delayed to line up with each blend level (stages 5..7)
   frac_type sx, sy, sz;
   vns_fade u_fx (.clock, .en, .t(fr_in.fx), .fade(sx));
   vns_fade u_fy (.clock, .en, .t(fr_in.fy), .fade(sy));
   vns_fade u_fz (.clock, .en, .t(fr_in.fz), .fade(sz));

   frac_type sx_d_ff, sy_d_ff [2], sz_d_ff [3];
   always_ff @(posedge clock) begin
      if (en) begin
         sx_d_ff    <= sx;
         sy_d_ff[0] <= sy;
         sy_d_ff[1] <= sy_d_ff[0];
         sz_d_ff[0] <= sz;
         sz_d_ff[1] <= sz_d_ff[0];
         sz_d_ff[2] <= sz_d_ff[1];
      end
   end

   // corners: stages 2..4
   value_type cv [8];
   for (genvar c = 0; c < 8; c++) begin : g_corner
      vns_corner u_c (
         .clock, .en, .seed(seed_ff),
         .hx(((c & 1) != 0) ? ah_ff.hx1 : ah_ff.hx0),
         .hy(((c & 2) != 0) ? ah_ff.hy1 : ah_ff.hy0),
         .hz(((c & 4) != 0) ? ah_ff.hz1 : ah_ff.hz0),
         .value(cv[c])
      );
   end

   value_type ex_ff [4], ey_ff [2], out_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) ex_ff[k] <= blend(cv[2*k], cv[2*k+1], sx_d_ff);
         ey_ff[0] <= blend(ex_ff[0], ex_ff[1], sy_d_ff[1]);
         ey_ff[1] <= blend(ex_ff[2], ex_ff[3], sy_d_ff[1]);
         out_ff   <= blend(ey_ff[0], ey_ff[1], sz_d_ff[2]);
      end
   end

   assign rsp_tdata = out_ff;

endmodule

// ----- design/vns_checker.sv -----
module vns_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready) else $error("ready low with empty output");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready ##1 rsp_tready [*6] |=> rsp_tvalid)
      else $error("result missing");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid) else $error("valid after reset");

endmodule

bind value_noise_3d_sampler vns_checker u_vns_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata
);
